@@ design/sha1_pkg.sv @@
package sha1_pkg;

  // Fixed sizes of the SHA-1 block and its state.
  localparam int unsigned POS_W      = 6;
  localparam int unsigned LEN_W      = 64;
  localparam int unsigned BLK_WORDS  = 16;
  localparam int unsigned NUM_WORDS  = 5;
  localparam int unsigned WORD_IDX_W = 3;
  localparam int unsigned ROUNDS     = 80;
  localparam int unsigned RND_W      = 7;

  // Byte positions that steer the padding.
  localparam logic [POS_W-1:0] LEN_POS  = 6'd56;
  localparam logic [POS_W-1:0] LAST_POS = 6'd63;
  localparam logic [7:0]       PAD_MARK = 8'h80;

  // Initial hash values.
  localparam logic [31:0] IV [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Round constants, one per group of twenty rounds.
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

  // Source of the byte written into the block.
  typedef enum logic [1:0] {
    SRC_MSG,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN
  } byte_src_e;

  typedef struct packed {
    logic                  byte_we;
    byte_src_e             byte_src;
    logic                  len_inc;
    logic                  load_work;
    logic                  round_en;
    logic [RND_W-1:0]      rnd;
    logic                  hash_add;
    logic                  hash_init;
    logic [WORD_IDX_W-1:0] word_idx;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
  } stat_t;

endpackage

@@ design/sha1_ifs.sv @@
// Message byte channel.
interface sha1_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, message_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, message_byte, has_byte, end_of_message, output ready);
endinterface

// Digest word channel.
interface sha1_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        last_word;

  modport source (output valid, digest_word, last_word, input ready);
  modport sink   (input valid, digest_word, last_word, output ready);
endinterface

@@ design/sha1_ctrl.sv @@
module sha1_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           has_byte_i,
  input  logic           eom_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  sha1_pkg::stat_t stat_i,
  output sha1_pkg::cmd_t cmd_o
);
  import sha1_pkg::*;

  state_e                state_q, state_d;
  logic [RND_W-1:0]      rnd_q, rnd_d;
  logic [WORD_IDX_W-1:0] widx_q, widx_d;
  logic                  fin_q, fin_d;
  logic                  mark_q, mark_d;
  logic                  len_q, len_d;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q   <= '0;
      widx_q  <= '0;
      fin_q   <= 1'b0;
      mark_q  <= 1'b0;
      len_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      widx_q  <= widx_d;
      fin_q   <= fin_d;
      mark_q  <= mark_d;
      len_q   <= len_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d        = state_q;
    rnd_d          = rnd_q;
    widx_d         = widx_q;
    fin_d          = fin_q;
    mark_d         = mark_q;
    len_d          = len_q;
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    cmd_o          = '0;
    cmd_o.byte_src = SRC_MSG;
    cmd_o.rnd      = rnd_q;
    cmd_o.word_idx = widx_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (has_byte_i) begin
            cmd_o.byte_we = 1'b1;
            cmd_o.len_inc = 1'b1;
          end
          if (has_byte_i && stat_i.pos == LAST_POS) begin
            // The block is full: compress it before anything else.
            cmd_o.load_work = 1'b1;
            rnd_d           = '0;
            fin_d           = eom_i;
            state_d         = ST_ROUND;
          end else if (eom_i) begin
            fin_d   = 1'b1;
            state_d = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        // One padding byte per cycle: the marker, zeros, then the length.
        cmd_o.byte_we = 1'b1;
        if (!mark_q) begin
          cmd_o.byte_src = SRC_MARK;
          mark_d         = 1'b1;
        end else if (len_q || stat_i.pos == LEN_POS) begin
          cmd_o.byte_src = SRC_LEN;
          len_d          = 1'b1;
        end else begin
          cmd_o.byte_src = SRC_ZERO;
        end
        if (stat_i.pos == LAST_POS) begin
          cmd_o.load_work = 1'b1;
          rnd_d           = '0;
          state_d         = ST_ROUND;
        end
      end

      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        if (rnd_q == RND_W'(ROUNDS - 1)) begin
          state_d = ST_ADD;
        end else begin
          rnd_d = rnd_q + 1'b1;
        end
      end

      ST_ADD: begin
        cmd_o.hash_add = 1'b1;
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (len_q) begin
          widx_d  = '0;
          state_d = ST_OUT;
        end else begin
          state_d = ST_PAD;
        end
      end

      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (widx_q == WORD_IDX_W'(NUM_WORDS - 1)) begin
            cmd_o.hash_init = 1'b1;
            fin_d           = 1'b0;
            mark_d          = 1'b0;
            len_d           = 1'b0;
            state_d         = ST_IDLE;
          end else begin
            widx_d = widx_q + 1'b1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/sha1_dp.sv @@
module sha1_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      message_byte_i,
  input  sha1_pkg::cmd_t  cmd_i,
  output sha1_pkg::stat_t stat_o,
  output logic [31:0]     digest_word_o,
  output logic            last_word_o
);
  import sha1_pkg::*;

  logic [POS_W-1:0] pos_q;
  logic [LEN_W-1:0] bitlen_q;
  logic [31:0]      hash_q [NUM_WORDS];
  logic [23:0]      acc_q;
  logic [31:0]      w_q [BLK_WORDS];
  logic [31:0]      a_q, b_q, c_q, d_q, e_q;

  logic [7:0]       len_byte;
  logic [7:0]       wr_byte;
  logic [31:0]      sched;
  logic [31:0]      wr;
  logic [31:0]      f;
  logic [31:0]      k;
  logic [31:0]      t;

  assign stat_o.pos = pos_q;

  // Length bytes go out most significant first from position 56 on.
  assign len_byte = 8'(bitlen_q >> {~pos_q[2:0], 3'b000});

  // Byte source selection.
  always_comb begin
    case (cmd_i.byte_src)
      SRC_MSG:  wr_byte = message_byte_i;
      SRC_MARK: wr_byte = PAD_MARK;
      SRC_ZERO: wr_byte = 8'h00;
      SRC_LEN:  wr_byte = len_byte;
      default:  wr_byte = 8'h00;
    endcase
  end

  // Message schedule taps: w_q[0] holds the oldest word.
  assign sched = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign wr    = (cmd_i.rnd < RND_W'(16)) ? w_q[0] : {sched[30:0], sched[31]};

  // Round function and constant.
  always_comb begin
    if (cmd_i.rnd < RND_W'(20)) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = K0;
    end else if (cmd_i.rnd < RND_W'(40)) begin
      f = b_q ^ c_q ^ d_q;
      k = K1;
    end else if (cmd_i.rnd < RND_W'(60)) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = K3;
    end
  end

  assign t = {a_q[26:0], a_q[31:27]} + f + e_q + k + wr;

  // Byte position, length count and running hash.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      bitlen_q <= '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        hash_q[i] <= IV[i];
      end
    end else begin
      if (cmd_i.byte_we) begin
        pos_q <= pos_q + 1'b1;
      end
      if (cmd_i.hash_init) begin
        bitlen_q <= '0;
      end else if (cmd_i.len_inc) begin
        bitlen_q <= bitlen_q + LEN_W'(8);
      end
      if (cmd_i.hash_init) begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          hash_q[i] <= IV[i];
        end
      end else if (cmd_i.hash_add) begin
        hash_q[0] <= hash_q[0] + a_q;
        hash_q[1] <= hash_q[1] + b_q;
        hash_q[2] <= hash_q[2] + c_q;
        hash_q[3] <= hash_q[3] + d_q;
        hash_q[4] <= hash_q[4] + e_q;
      end
    end
  end

  // Byte packing and the schedule shift line; both shift toward w_q[0].
  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_we) begin
      if (pos_q[1:0] == 2'b11) begin
        for (int i = 0; i < BLK_WORDS - 1; i++) begin
          w_q[i] <= w_q[i+1];
        end
        w_q[BLK_WORDS-1] <= {acc_q, wr_byte};
      end else begin
        acc_q <= {acc_q[15:0], wr_byte};
      end
    end else if (cmd_i.round_en) begin
      for (int i = 0; i < BLK_WORDS - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[BLK_WORDS-1] <= wr;
    end
  end

  // Working variables.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_work) begin
      a_q <= hash_q[0];
      b_q <= hash_q[1];
      c_q <= hash_q[2];
      d_q <= hash_q[3];
      e_q <= hash_q[4];
    end else if (cmd_i.round_en) begin
      a_q <= t;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  // Digest word selection.
  always_comb begin
    case (cmd_i.word_idx)
      3'd0:    digest_word_o = hash_q[0];
      3'd1:    digest_word_o = hash_q[1];
      3'd2:    digest_word_o = hash_q[2];
      3'd3:    digest_word_o = hash_q[3];
      3'd4:    digest_word_o = hash_q[4];
      default: digest_word_o = hash_q[0];
    endcase
  end

  assign last_word_o = (cmd_i.word_idx == WORD_IDX_W'(NUM_WORDS - 1));

endmodule

@@ design/sha1_stream_hasher.sv @@
// Streaming SHA-1 hasher. Message bytes enter one per word on byte_i; a word with
// end_of_message set pads the message and the five digest words h0..h4 leave on
// digest_o, the last one flagged by last_word. A byte word is taken whenever
// the hasher is idle. Each full 64-byte block stalls the input while it runs
// through the single-round unit and then the hash update. At the end of a
// message the padding bytes go through the same byte path at one per cycle
// (up to 64, or up to 72 when a second block is needed), each filled block is
// compressed the same way, and then the digest is offered one word per cycle
// while digest_o.ready is high. No new word is taken until the digest is drained.
module sha1_stream_hasher (
  input  logic          clk_i,
  input  logic          rst_ni,
  sha1_byte_if.sink     byte_i,
  sha1_digest_if.source digest_o
);
  import sha1_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sha1_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (byte_i.valid),
    .has_byte_i  (byte_i.has_byte),
    .eom_i       (byte_i.end_of_message),
    .in_ready_o  (byte_i.ready),
    .out_valid_o (digest_o.valid),
    .out_ready_i (digest_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sha1_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .message_byte_i (byte_i.message_byte),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .digest_word_o  (digest_o.digest_word),
    .last_word_o    (digest_o.last_word)
  );

endmodule

@@ design/sha1_chk.sv @@
module sha1_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        eom_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] digest_word_i,
  input logic        last_word_i
);

  // The digest is never offered while message bytes are taken.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_i && in_ready_i))
    else $error("digest offered while the input is ready");

  // A stalled digest word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(digest_word_i)
      && $stable(last_word_i))
    else $error("stalled digest word changed");

  // The digest words follow one another until the last one.
  a_out_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_word_i |=> out_valid_i)
    else $error("digest burst broken");

  // After the last word the block returns to idle.
  a_out_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && last_word_i |=> !out_valid_i && in_ready_i)
    else $error("block did not return to idle after the digest");

  // An end of message starts padding or a block compression, so the input closes.
  a_eom_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && eom_i |=> !in_ready_i)
    else $error("input stayed open after end of message");

endmodule

bind sha1_stream_hasher sha1_chk u_sha1_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (byte_i.valid),
  .in_ready_i    (byte_i.ready),
  .eom_i         (byte_i.end_of_message),
  .out_valid_i   (digest_o.valid),
  .out_ready_i   (digest_o.ready),
  .digest_word_i (digest_o.digest_word),
  .last_word_i   (digest_o.last_word)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

  // One word on the message channel.
  typedef struct packed {
    logic [7:0] msg;
    logic       has;
    logic       fin;
  } byte_item_t;

  // One expected word on the digest channel.
  typedef struct packed {
    logic [31:0] word;
    logic        is_last;
  } digest_t;

  localparam logic [31:0] SHA_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [31:0] RC_00_19 = 32'h5A827999;
  localparam logic [31:0] RC_20_39 = 32'h6ED9EBA1;
  localparam logic [31:0] RC_40_59 = 32'h8F1BBCDC;
  localparam logic [31:0] RC_60_79 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LENGTH_SLOT = 6'd56;

  localparam int NUM_PHASES = 4;
  localparam int PH_IDLE  [NUM_PHASES] = '{0, 64, 0, 38};
  localparam int PH_STALL [NUM_PHASES] = '{0, 0, 64, 38};
  // Message lengths around the point where the length no longer fits the block.
  localparam int EDGE_LEN [NUM_PHASES] = '{55, 56, 63, 64};
  localparam int ITEMS_PER_PHASE = 72;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  logic clk_i;
  logic rst_ni;

  sha1_byte_if   byte_if ();
  sha1_digest_if digest_if ();

  sha1_stream_hasher dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .digest_o (digest_if)
  );

  byte_item_t byte_backlog [$];
  digest_t    digest_expect [$];
  byte_item_t next_item;
  digest_t    want;

  int idle_pct;
  int stall_pct;
  int error_count;
  int items_queued;
  logic hold_arm;
  int hold_left;

  // Running SHA-1 state of the predictor.
  logic [31:0] run_hash [5];
  logic [31:0] run_block [16];
  logic [5:0]  run_pos;
  logic [63:0] run_bits;

  function automatic logic [31:0] rol32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void restart_hash();
    foreach (run_hash[i]) run_hash[i] = SHA_INIT[i];
    run_pos  = '0;
    run_bits = '0;
  endfunction

  // Eighty rounds over the current block, folded into the running hash.
  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, wr, t;
    w = run_block;
    a = run_hash[0];
    b = run_hash[1];
    c = run_hash[2];
    d = run_hash[3];
    e = run_hash[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        wr = rol32(w[(r - 3) & 15] ^ w[(r - 8) & 15] ^ w[(r - 14) & 15] ^ w[r & 15], 1);
        w[r & 15] = wr;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = RC_00_19;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RC_20_39;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RC_40_59;
      end else begin
        f = b ^ c ^ d;
        k = RC_60_79;
      end
      t = rol32(a, 5) + f + e + k + wr;
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    run_hash[0] += a;
    run_hash[1] += b;
    run_hash[2] += c;
    run_hash[3] += d;
    run_hash[4] += e;
  endfunction

  // Big-endian byte packing; a full block is compressed at once.
  function automatic void absorb_byte(logic [7:0] v);
    logic [3:0] wi;
    int sh;
    wi = run_pos[5:2];
    sh = (3 - run_pos[1:0]) * 8;
    if (run_pos[1:0] == 2'd0) run_block[wi] = '0;
    run_block[wi] |= 32'(v) << sh;
    run_pos = run_pos + 6'd1;
    if (run_pos == 6'd0) compress_block();
  endfunction

  // Applies one accepted word and queues the digest it produces, if any.
  function automatic void predict_digest(byte_item_t it);
    if (it.has) begin
      absorb_byte(it.msg);
      run_bits += 64'd8;
    end
    if (it.fin) begin
      absorb_byte(PAD_BYTE);
      while (run_pos != LENGTH_SLOT) absorb_byte(8'h00);
      run_block[14] = run_bits[63:32];
      run_block[15] = run_bits[31:0];
      compress_block();
      for (int i = 0; i < 5; i++) digest_expect.push_back('{run_hash[i], i == 4});
      restart_hash();
    end
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] expected, logic [31:0] actual);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected %08h, got %08h", $realtime, what, expected, actual);
    end
  endtask

  task automatic push_word(logic [7:0] msg, logic has, logic fin);
    byte_backlog.push_back('{msg, has, fin});
    items_queued++;
  endtask

  // A message of n bytes with random content and an occasional ignored word.
  task automatic queue_message(int n_bytes);
    logic fin_on_byte;
    fin_on_byte = 1'b0;
    for (int i = 0; i < n_bytes; i++) begin
      if ($urandom_range(11) == 0) push_word(8'($urandom), 1'b0, 1'b0);
      fin_on_byte = (i == n_bytes - 1) && $urandom_range(1);
      push_word(8'($urandom), 1'b1, fin_on_byte);
    end
    if (!fin_on_byte) push_word(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic int pick_length();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) return $urandom_range(12);
    if (sel < 8) return $urandom_range(70, 50);
    if (sel == 8) return $urandom_range(130, 120);
    return EDGE_LEN[$urandom_range(NUM_PHASES - 1)];
  endfunction

  // Waits until every queued word is taken and every digest word has come.
  task automatic wait_drained();
    while (byte_backlog.size() != 0 || byte_if.valid || digest_expect.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Message word driver, fed from the backlog.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      byte_if.valid <= 1'b0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        predict_digest('{byte_if.message_byte, byte_if.has_byte, byte_if.end_of_message});
      end
      if (!byte_if.valid || byte_if.ready) begin
        if (byte_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_item = byte_backlog.pop_front();
          byte_if.message_byte   <= next_item.msg;
          byte_if.has_byte       <= next_item.has;
          byte_if.end_of_message <= next_item.fin;
          byte_if.valid          <= 1'b1;
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down here.
  always @(posedge clk_i) begin
    if (hold_arm) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Digest word monitor and checker.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      digest_if.ready <= 1'b0;
    end else begin
      if (digest_if.valid && digest_if.ready) begin
        if (digest_expect.size() == 0) begin
          flag_mismatch("unexpected digest word", '0, digest_if.digest_word);
        end else begin
          want = digest_expect.pop_front();
          if (want.word !== digest_if.digest_word) begin
            flag_mismatch("digest_word", want.word, digest_if.digest_word);
          end
          if (want.is_last !== digest_if.last_word) begin
            flag_mismatch("last_word", 32'(want.is_last), 32'(digest_if.last_word));
          end
        end
      end
      digest_if.ready <= !(hold_arm || hold_left != 0) && $urandom_range(99) >= stall_pct;
    end
  end

  // Stimulus: directed words, then random messages in idling phases.
  initial begin
    rst_ni = 1'b0;
    byte_if.valid = 1'b0;
    byte_if.message_byte = '0;
    byte_if.has_byte = 1'b0;
    byte_if.end_of_message = 1'b0;
    digest_if.ready = 1'b0;
    hold_arm = 1'b0;
    hold_left = 0;
    idle_pct = 0;
    stall_pct = 0;
    error_count = 0;
    items_queued = 0;
    foreach (run_block[i]) run_block[i] = '0;
    restart_hash();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty message, ignored words, single byte ending with its own word.
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'h00, 1'b0, 1'b0);
    push_word(8'hFF, 1'b0, 1'b0);
    push_word(8'h00, 1'b1, 1'b1);
    // Byte extremes, then an end without a byte.
    push_word(8'hFF, 1'b1, 1'b0);
    push_word(8'h80, 1'b1, 1'b0);
    push_word(8'h7F, 1'b1, 1'b0);
    push_word(8'hFF, 1'b0, 1'b1);
    // The classic "abc" message.
    push_word(8'h61, 1'b1, 1'b0);
    push_word(8'h62, 1'b1, 1'b0);
    push_word(8'h63, 1'b1, 1'b1);
    push_word(8'h55, 1'b1, 1'b0);
    push_word(8'hAA, 1'b1, 1'b1);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_pct  = PH_IDLE[ph];
      stall_pct = PH_STALL[ph];
      if (ph == 0) begin
        // Hold the digest side off while the sender keeps offering bytes.
        @(posedge clk_i);
        hold_arm <= 1'b1;
        @(posedge clk_i);
        hold_arm <= 1'b0;
      end
      queue_message(EDGE_LEN[ph]);
      while (items_queued < 13 + (ph + 1) * ITEMS_PER_PHASE) queue_message(pick_length());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && digest_expect.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
design/sha1_pkg.sv
design/sha1_ifs.sv
design/sha1_ctrl.sv
design/sha1_dp.sv
design/sha1_stream_hasher.sv
design/sha1_chk.sv
tb/tb.sv
